### sv/ffd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_pkg
// shared types and constants of the flood relay with duplicate suppression
// ----------------------------------------------------------------------------
package ffd_pkg;

    localparam int SEEN_DEPTH_DEF = 64;
    localparam int NODE_COUNT_DEF = 16;

    localparam int SRC_W   = 4;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam int ID_W    = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [SRC_W-1:0]         pkt_source;
        logic signed [DATA_W-1:0] pkt_sequence;
        logic signed [DATA_W-1:0] pkt_payload;
    } pkt_t;

    typedef struct packed {
        logic                     forward;
        logic [ID_W-1:0]          fwd_source;
        logic signed [DATA_W-1:0] fwd_sequence;
        logic signed [DATA_W-1:0] fwd_payload;
        logic [COUNT_W-1:0]       source_count;
        logic                     table_full;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [SRC_W-1:0] src;
    } cnt_req_t;

endpackage

### sv/ffd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_cell
// one entry of the seen-payload row: holds a value, shifts it to the next
// cell on append and flags a match against the incoming payload
// ----------------------------------------------------------------------------
module ffd_cell
    import ffd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     shift_en,
    input  logic signed [DATA_W-1:0] shift_in,
    output logic signed [DATA_W-1:0] shift_out,
    input  logic                     active,
    input  logic signed [DATA_W-1:0] key,
    output logic                     match
);

    logic signed [DATA_W-1:0] value_reg;
    logic                     match_reg;
    logic                     match_next;

    // inactive cells may hold unwritten data, gated here
    assign match_next = active && (value_reg == key);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            value_reg <= shift_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign shift_out = value_reg;
    assign match     = match_reg;

endmodule

### sv/ffd_src_count.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffd_src_count
// per-source saturating packet counters
// ----------------------------------------------------------------------------
module ffd_src_count
    import ffd_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cnt_req_t           req,
    output logic [COUNT_W-1:0] count
);

    localparam int IDX_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [COUNT_W-1:0] cnt_reg [NODE_COUNT];
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic [COUNT_W-1:0] cur;
    logic [COUNT_W-1:0] cnt_next;

    assign in_range = (32'(req.src) < 32'(NODE_COUNT));
    assign idx      = IDX_W'(req.src);
    assign cur      = in_range ? cnt_reg[idx] : '0;
    assign cnt_next = (cur == COUNT_MAX) ? cur : cur + COUNT_W'(1);
    assign count    = in_range ? cnt_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else if (req.en && in_range)
        begin
            cnt_reg[idx] <= cnt_next;
        end
    end

endmodule

### sv/flood_forward_dedup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flood_forward_dedup_core
// flood relay: counts packets per source, drops payloads already seen,
// forwards new ones with sequence + 1 and this node's id as source
// ----------------------------------------------------------------------------
//  channel | signals                      | beat
//  in      | in_valid, in_stall, in_data  | one received packet (pkt_t)
//  out     | out_valid, out_stall, out_data | one result (res_t)
//  cfg     | cfg_valid, cfg_ready, cfg_data | node_id write
//
//  one packet in flight at a time: the cell row compares the payload at the
//  accept edge, the next edge resolves the hit, appends and loads the result
//  the payload row is a shift line of SEEN_DEPTH cells, filled from cell 0
//  reset clears the fill count and the source counters at once, no sweep
//  in_stall is high while a packet is in flight or a result waits stalled
// ----------------------------------------------------------------------------
module flood_forward_dedup_core
    import ffd_pkg::*;
#(
    parameter int SEEN_DEPTH = SEEN_DEPTH_DEF,
    parameter int NODE_COUNT = NODE_COUNT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  pkt_t            in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output res_t            out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [ID_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(SEEN_DEPTH + 1);

    logic                     busy_reg;
    logic                     busy_next;
    pkt_t                     item_reg;
    res_t                     out_reg;
    res_t                     out_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [ID_W-1:0]          node_id_reg;
    logic [CNT_W-1:0]         seen_count_reg;
    logic [CNT_W-1:0]         seen_count_next;

    logic                     in_take;
    logic                     hit;
    logic                     is_new;
    logic                     room;
    logic                     store;
    logic [SEEN_DEPTH-1:0]    match_vec;
    logic [SEEN_DEPTH-1:0]    active_vec;
    logic signed [DATA_W-1:0] chain [SEEN_DEPTH+1];
    cnt_req_t                 cnt_req;
    logic [COUNT_W-1:0]       src_count;

    assign in_stall  = busy_reg || (out_valid_reg && out_stall);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // payload row
    assign chain[0] = item_reg.pkt_payload;

    for (genvar i = 0; i < SEEN_DEPTH; i++)
    begin : g_cell
        assign active_vec[i] = (seen_count_reg > CNT_W'(i));

        ffd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .shift_en  (store),
            .shift_in  (chain[i]),
            .shift_out (chain[i+1]),
            .active    (active_vec[i]),
            .key       (in_data.pkt_payload),
            .match     (match_vec[i])
        );
    end

    assign hit    = |match_vec;
    assign is_new = busy_reg && !hit;
    assign room   = (seen_count_reg < CNT_W'(SEEN_DEPTH));
    assign store  = is_new && room;

    assign cnt_req.en  = busy_reg;
    assign cnt_req.src = item_reg.pkt_source;

    ffd_src_count #(
        .NODE_COUNT (NODE_COUNT)
    ) u_src_count (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .count (src_count)
    );

    always_comb
    begin
        busy_next       = busy_reg;
        seen_count_next = seen_count_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (busy_reg)
        begin
            busy_next               = 1'b0;
            out_valid_next          = 1'b1;
            out_next.forward        = !hit;
            out_next.fwd_source     = hit ? '0 : node_id_reg;
            out_next.fwd_sequence   = hit ? '0 : item_reg.pkt_sequence + 32'sd1;
            out_next.fwd_payload    = hit ? '0 : item_reg.pkt_payload;
            out_next.source_count   = src_count;
            out_next.table_full     = !hit && !room;
            if (store)
            begin
                seen_count_next = seen_count_reg + CNT_W'(1);
            end
        end
        else if (in_take)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            seen_count_reg <= '0;
            node_id_reg    <= '0;
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            seen_count_reg <= seen_count_next;
            if (cfg_valid && cfg_ready)
            begin
                node_id_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg <= in_data;
        end
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // result slot is always free when a packet resolves
    a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !out_valid_reg)
        else $error("result register busy at resolve");

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> !busy_reg)
        else $error("resolve phase longer than one cycle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_count_reg <= CNT_W'(SEEN_DEPTH))
        else $error("seen count beyond table depth");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.table_full) |-> (seen_count_reg == CNT_W'(SEEN_DEPTH)))
        else $error("table full flagged with room left");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(in_valid))
        else $error("busy without an accepted packet");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for flood_forward_dedup_core: a queue-fed driver offers
// packets in random bursts, a monitor checks every result against an in-bench
// relay predictor (per-source tallies, seen payload table, forward rules)
// ----------------------------------------------------------------------------
module tb_top;
    import ffd_pkg::*;

    localparam int  SEEN_DEPTH  = SEEN_DEPTH_DEF;
    localparam int  NODE_COUNT  = NODE_COUNT_DEF;
    localparam int  CYCLE_LIMIT = 5000000;
    localparam int  PIN_ITEMS   = 200;

    typedef enum int { RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE } rx_mode_t;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_stall;
    pkt_t            in_data   = '0;
    logic            out_valid;
    logic            out_stall = 1'b0;
    res_t            out_data;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [ID_W-1:0] cfg_data  = '0;

    // relay predictor state
    logic [DATA_W-1:0]  seen_pay [SEEN_DEPTH];
    int                 seen_fill = 0;
    logic [COUNT_W-1:0] src_tally [NODE_COUNT];
    logic [ID_W-1:0]    my_id = '0;

    pkt_t               pkt_backlog [$];
    res_t               due_results [$];
    logic [DATA_W-1:0]  sent_pay [$];

    int                 pkts_in   = 0;
    int                 err_cnt   = 0;
    int                 res_seen  = 0;
    int                 cyc       = 0;

    // sender burst state
    int                 gap_left   = 0;
    int                 burst_left = 0;

    // receiver stall state
    rx_mode_t           rx_mode   = RX_FREE;
    int                 mode_left = 0;
    int                 hold_left = 0;
    logic               hold_done = 1'b0;
    logic               rx_stall;
    res_t               want;

    flood_forward_dedup_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            src_tally[i] = '0;
        end
    end

    function automatic res_t relay_outcome(input pkt_t p);
        res_t r;
        logic hit;
        r   = '0;
        hit = 1'b0;
        if (int'(p.pkt_source) < NODE_COUNT)
        begin
            if (src_tally[p.pkt_source] != COUNT_MAX)
            begin
                src_tally[p.pkt_source] = src_tally[p.pkt_source] + COUNT_W'(1);
            end
            r.source_count = src_tally[p.pkt_source];
        end
        for (int i = 0; i < seen_fill; i++)
        begin
            if (seen_pay[i] == p.pkt_payload)
            begin
                hit = 1'b1;
            end
        end
        if (!hit)
        begin
            if (seen_fill < SEEN_DEPTH)
            begin
                seen_pay[seen_fill] = p.pkt_payload;
                seen_fill++;
            end
            else
            begin
                r.table_full = 1'b1;
            end
            r.forward      = 1'b1;
            r.fwd_source   = my_id;
            r.fwd_sequence = p.pkt_sequence + 32'sd1;
            r.fwd_payload  = p.pkt_payload;
        end
        return r;
    endfunction

    // driver: bursts of random length, gaps in between, payload held while stalled
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due_results.push_back(relay_outcome(in_data));
                pkts_in <= pkts_in + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pkt_backlog.size() > 0)
                begin
                    in_data  <= pkt_backlog.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                res_seen++;
                if (due_results.size() == 0)
                begin
                    if (err_cnt < 10)
                    begin
                        $display("result %0d with nothing expected:", res_seen);
                        $display("    got fwd=%0b src=%0d seq=%h pay=%h cnt=%0d full=%0b",
                                 out_data.forward, out_data.fwd_source,
                                 out_data.fwd_sequence, out_data.fwd_payload,
                                 out_data.source_count, out_data.table_full);
                    end
                    err_cnt++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (out_data.forward      !== want.forward      ||
                        out_data.fwd_source   !== want.fwd_source   ||
                        out_data.fwd_sequence !== want.fwd_sequence ||
                        out_data.fwd_payload  !== want.fwd_payload  ||
                        out_data.source_count !== want.source_count ||
                        out_data.table_full   !== want.table_full)
                    begin
                        if (err_cnt < 10)
                        begin
                            $display("result %0d mismatch:", res_seen);
                            $display("    exp fwd=%0b src=%0d seq=%h pay=%h cnt=%0d full=%0b",
                                     want.forward, want.fwd_source, want.fwd_sequence,
                                     want.fwd_payload, want.source_count, want.table_full);
                            $display("    got fwd=%0b src=%0d seq=%h pay=%h cnt=%0d full=%0b",
                                     out_data.forward, out_data.fwd_source,
                                     out_data.fwd_sequence, out_data.fwd_payload,
                                     out_data.source_count, out_data.table_full);
                        end
                        err_cnt++;
                    end
                end
            end

            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 200);
            end
            else
            begin
                mode_left--;
            end
            // one long hold-off so the core backs up and stalls its input
            if (!hold_done && pkts_in >= 200)
            begin
                hold_done = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rx_stall = 1'b1;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:  rx_stall = 1'b0;
                    RX_LIGHT: rx_stall = ($urandom_range(0, 7) == 0);
                    RX_HEAVY: rx_stall = ($urandom_range(0, 3) != 0);
                    default:  rx_stall = ~out_stall;
                endcase
            end
            out_stall <= rx_stall;
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    task automatic push_pkt(input int src, input logic [DATA_W-1:0] seq,
                            input logic [DATA_W-1:0] pay);
        pkt_t p;
        p.pkt_source   = SRC_W'(src);
        p.pkt_sequence = seq;
        p.pkt_payload  = pay;
        pkt_backlog.push_back(p);
        sent_pay.push_back(pay);
    endtask

    // src_pin < 0 means random source per packet
    task automatic queue_random(input int n, input int src_pin, input int dup_pct);
        pkt_t p;
        int   span;
        for (int k = 0; k < n; k++)
        begin
            p.pkt_source = (src_pin < 0) ? SRC_W'($urandom_range(0, NODE_COUNT - 1))
                                         : SRC_W'(src_pin);
            case ($urandom_range(0, 9))
                0:       p.pkt_sequence = 32'h7fff_ffff;
                1:       p.pkt_sequence = 32'hffff_ffff;
                2:       p.pkt_sequence = 32'h8000_0000;
                default: p.pkt_sequence = $urandom;
            endcase
            if (sent_pay.size() > 0 && $urandom_range(0, 99) < dup_pct)
            begin
                // early payloads are the ones that made it into the table
                span = $urandom_range(0, 1) ? sent_pay.size() :
                       (sent_pay.size() < SEEN_DEPTH ? sent_pay.size() : SEEN_DEPTH);
                p.pkt_payload = sent_pay[$urandom_range(0, span - 1)];
            end
            else
            begin
                p.pkt_payload = $urandom;
                sent_pay.push_back(p.pkt_payload);
            end
            pkt_backlog.push_back(p);
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
        end
        while (pkt_backlog.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_node_id(input logic [ID_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        my_id = v;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_node_id(4'd0);
        write_node_id(4'd15);

        // field extremes, sequence wrap, duplicates, every source
        push_pkt(0,  32'h0000_0000, 32'h0000_0000);
        push_pkt(15, 32'h7fff_ffff, 32'hffff_ffff);
        push_pkt(0,  32'h8000_0000, 32'h7fff_ffff);
        push_pkt(15, 32'hffff_ffff, 32'h8000_0000);
        push_pkt(1,  32'h0000_0001, 32'h0000_0000);
        push_pkt(2,  32'h1234_5678, 32'hffff_ffff);
        push_pkt(3,  32'hffff_ffff, 32'h7fff_ffff);
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            push_pkt(i, $urandom, (i % 2 == 0) ? $urandom : 32'h8000_0000);
        end
        wait_drained();

        // table fills up here
        write_node_id(4'd0);
        queue_random(400, -1, 40);
        wait_drained();

        // table full: stored duplicates, new payloads, repeats of unstored ones
        write_node_id(ID_W'($urandom_range(1, 14)));
        queue_random(300, -1, 50);
        wait_drained();

        // hammer one source
        write_node_id(4'd15);
        queue_random(PIN_ITEMS, $urandom_range(0, NODE_COUNT - 1), 70);
        wait_drained();

        write_node_id(4'd0);
        queue_random(300, -1, 50);
        wait_drained();

        if (due_results.size() != 0)
        begin
            err_cnt++;
        end
        if (err_cnt == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

### sim.f
sv/ffd_pkg.sv
sv/ffd_cell.sv
sv/ffd_src_count.sv
sv/flood_forward_dedup_core.sv
verif/tb_top.sv
